/* rtl/cstk_pkg.sv */
// ----------------------------------------------------------------------------
// cstk_pkg: shared definitions for the coordinate stack
// Sizes, command and status codes, and the types passed between the control
// logic and the row of stack cells.
// ----------------------------------------------------------------------------
package cstk_pkg;

	// Sizes
	localparam int STACK_DEPTH = 64;
	localparam int COORD_BITS  = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// Stream payload widths, padded to whole bytes
	localparam int IN_BITS  = 2 + 2 * COORD_BITS;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 2 * COORD_BITS + 1 + 2;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Command codes
	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_PEEK   = 2'd1,
		OP_POP    = 2'd2,
		OP_SEARCH = 2'd3
	} op_e_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_e_t;

	// Control sequencer states
	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EVAL = 2'd1,
		S_OUT  = 2'd2
	} state_e_t;

	// One stored coordinate pair
	typedef struct packed {
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] x;
	} pair_t;

	// Control broadcast to every cell
	typedef struct packed {
		logic  shift_dn;  // push: every entry moves one cell deeper
		logic  shift_up;  // pop: every entry moves one cell toward the top
		logic  search;    // compare the key against the held entry
		pair_t key;       // pair being pushed or searched for
	} cell_ctrl_t;

endpackage

/* rtl/coordinate_stack_with_search_unit.sv */
// ----------------------------------------------------------------------------
// coordinate_stack_with_search_unit: LIFO of (x,y) pairs with membership search
// A row of cells holds the stack, top in the first cell; push and pop shift
// the whole row by one and each cell compares its own pair on a search.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions arrive on s_axis (opcode, x, y); every transaction
//   yields exactly one result transaction on m_axis (top_x, top_y, found,
//   status). Push stores a pair (status full when all slots are used), peek
//   and pop return the top pair (-1,-1 with status empty on an empty stack),
//   search reports whether the pair is held.
//   One item is handled at a time: s_axis_tready is high only while idle.
//   The result passes through the cells' registered compare and the output
//   register before it is presented on m_axis; a new item is taken only
//   after the result of the last one has been accepted.
//   If the receiver stalls, the result holds on m_axis and no new input is
//   taken until it is accepted.
//   Reset empties the stack (count to zero) and drops any pending result;
//   the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module coordinate_stack_with_search_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// [1:0] opcode, [17:2] x_coord, [33:18] y_coord, rest zero
	input  logic [cstk_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// [15:0] top_x, [31:16] top_y, [32] found, [34:33] status, rest zero
	output logic [cstk_pkg::OUT_W-1:0] m_axis_tdata
);

	localparam int CB = cstk_pkg::COORD_BITS;

	// Input field extraction
	cstk_pkg::op_e_t in_op;
	cstk_pkg::pair_t in_pair;
	assign in_op     = cstk_pkg::op_e_t'(s_axis_tdata[1:0]);
	assign in_pair.x = s_axis_tdata[2 +: CB];
	assign in_pair.y = s_axis_tdata[2 + CB +: CB];

	// Sequencer and stack registers
	cstk_pkg::state_e_t              state_q, state_d;
	logic [cstk_pkg::CNT_W-1:0]      count_q, count_d;
	logic                            search_q;
	logic                            load_res;
	cstk_pkg::pair_t                 res_pair_q, res_pair_d;
	cstk_pkg::status_e_t             res_status_q, res_status_d;
	logic                            found_q;
	cstk_pkg::cell_ctrl_t            ctrl;
	logic                            in_xact;
	logic                            stack_full, stack_empty;

	cstk_pkg::pair_t                 cell_pair [cstk_pkg::STACK_DEPTH];
	logic [cstk_pkg::STACK_DEPTH-1:0] match_s1;

	assign in_xact     = s_axis_tvalid && s_axis_tready;
	assign stack_full  = (count_q == cstk_pkg::CNT_W'(cstk_pkg::STACK_DEPTH));
	assign stack_empty = (count_q == '0);

	// Next state, cell control and result capture
	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		s_axis_tready = 1'b0;
		load_res      = 1'b0;
		res_pair_d    = '0;
		res_status_d  = cstk_pkg::ST_OK;
		ctrl.shift_dn = 1'b0;
		ctrl.shift_up = 1'b0;
		ctrl.search   = 1'b0;
		ctrl.key      = in_pair;
		case (state_q)
			cstk_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					load_res = 1'b1;
					state_d  = cstk_pkg::S_EVAL;
					case (in_op)
						cstk_pkg::OP_PUSH: begin
							if (stack_full) begin
								res_status_d = cstk_pkg::ST_FULL;
							end else begin
								ctrl.shift_dn = 1'b1;
								count_d       = count_q + 1'b1;
							end
						end
						cstk_pkg::OP_PEEK, cstk_pkg::OP_POP: begin
							if (stack_empty) begin
								res_pair_d   = '1;
								res_status_d = cstk_pkg::ST_EMPTY;
							end else begin
								res_pair_d = cell_pair[0];
								if (in_op == cstk_pkg::OP_POP) begin
									ctrl.shift_up = 1'b1;
									count_d       = count_q - 1'b1;
								end
							end
						end
						cstk_pkg::OP_SEARCH: begin
							ctrl.search = 1'b1;
						end
						default: begin
							ctrl.search = 1'b0;
						end
					endcase
				end
			end
			cstk_pkg::S_EVAL: begin
				state_d = cstk_pkg::S_OUT;
			end
			cstk_pkg::S_OUT: begin
				if (m_axis_tready) begin
					state_d = cstk_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cstk_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cstk_pkg::S_IDLE;
			count_q  <= '0;
			search_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (in_xact) begin
				search_q <= ctrl.search;
			end
		end
	end

	// Result payload registers
	always_ff @(posedge clk) begin
		if (load_res) begin
			res_pair_q   <= res_pair_d;
			res_status_q <= res_status_d;
		end
		if (state_q == cstk_pkg::S_EVAL) begin
			found_q <= search_q && (|match_s1);
		end
	end

	// Row of stack cells, top at index 0
	for (genvar i = 0; i < cstk_pkg::STACK_DEPTH; i++) begin : g_cell
		cstk_pkg::pair_t above, below;
		logic            occ;
		if (i == 0) begin : g_top
			assign above = in_pair;
		end else begin : g_mid
			assign above = cell_pair[i-1];
		end
		if (i == cstk_pkg::STACK_DEPTH - 1) begin : g_bot
			assign below = cell_pair[i];
		end else begin : g_inner
			assign below = cell_pair[i+1];
		end
		assign occ = (cstk_pkg::CNT_W'(i) < count_q);

		cstk_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.occupied   (occ),
			.pair_above (above),
			.pair_below (below),
			.pair_q     (cell_pair[i]),
			.match_s1   (match_s1[i])
		);
	end

	// Output channel
	assign m_axis_tvalid = (state_q == cstk_pkg::S_OUT);
	assign m_axis_tdata  = {
		{(cstk_pkg::OUT_W - cstk_pkg::OUT_BITS){1'b0}},
		res_status_q,
		found_q,
		res_pair_q.y,
		res_pair_q.x
	};

endmodule

/* rtl/cstk_cell.sv */
// ----------------------------------------------------------------------------
// cstk_cell: one slot of the shifting stack
// Holds one pair, takes its neighbor's pair on push or pop, and registers
// whether its pair equals the search key.
// ----------------------------------------------------------------------------
module cstk_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cstk_pkg::cell_ctrl_t ctrl,
	input  logic                 occupied,   // this slot holds a pushed pair
	input  cstk_pkg::pair_t      pair_above, // neighbor nearer the top
	input  cstk_pkg::pair_t      pair_below, // neighbor deeper in the stack
	output cstk_pkg::pair_t      pair_q,
	output logic                 match_s1
);

	// Stored pair: shifts down on push, up on pop
	always_ff @(posedge clk) begin
		if (ctrl.shift_dn) begin
			pair_q <= pair_above;
		end else if (ctrl.shift_up) begin
			pair_q <= pair_below;
		end
	end

	// Local comparator, registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_s1 <= 1'b0;
		end else begin
			match_s1 <= ctrl.search && occupied && (pair_q == ctrl.key);
		end
	end

endmodule

/* tb/sv/tb_coordinate_stack_with_search_unit.sv */
// ----------------------------------------------------------------------------
// tb_coordinate_stack_with_search_unit: stream-level test of the coordinate stack
// Drives push, peek, pop and search commands with random idle gaps on the
// input side and random back-pressure on the result side. A shadow stack
// predicts every result, and each result is compared field by field with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_coordinate_stack_with_search_unit;
	import cstk_pkg::*;

	localparam int RANDOM_ITEMS = 1500;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 10;
	localparam int POOL_SIZE    = 24;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// Expected result of one command
	typedef struct packed {
		status_e_t status;
		logic      found;
		coord_t    top_y;
		coord_t    top_x;
	} stack_result_t;

	typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

	// Shadow stack plus the queue of results it has predicted
	class coord_stack_checker;
		pair_t         shadow_stack[STACK_DEPTH];
		int            held;
		stack_result_t owed_results[$];
		int            results_checked, mismatches, errors;
		int            n_push, n_full, n_read, n_empty, n_search, n_hit, peak_held;

		function new();
			held = 0;
			results_checked = 0; mismatches = 0; errors = 0;
			n_push = 0; n_full = 0; n_read = 0; n_empty = 0;
			n_search = 0; n_hit = 0; peak_held = 0;
		endfunction

		// Advance the shadow stack by one accepted command and queue its result
		function void accept_command(op_e_t op, coord_t x, coord_t y);
			stack_result_t r;
			r.top_x  = '0;
			r.top_y  = '0;
			r.found  = 1'b0;
			r.status = ST_OK;
			case (op)
				OP_PUSH: begin
					n_push++;
					if (held >= STACK_DEPTH) begin
						r.status = ST_FULL;
						n_full++;
					end else begin
						shadow_stack[held].x = x;
						shadow_stack[held].y = y;
						held++;
						if (held > peak_held) peak_held = held;
					end
				end
				OP_PEEK, OP_POP: begin
					n_read++;
					if (held == 0) begin
						r.top_x  = '1;
						r.top_y  = '1;
						r.status = ST_EMPTY;
						n_empty++;
					end else begin
						r.top_x = shadow_stack[held-1].x;
						r.top_y = shadow_stack[held-1].y;
						if (op == OP_POP) held--;
					end
				end
				OP_SEARCH: begin
					n_search++;
					for (int i = 0; i < held; i++)
						if (shadow_stack[i].x == x && shadow_stack[i].y == y)
							r.found = 1'b1;
					if (r.found) n_hit++;
				end
				default: ;
			endcase
			owed_results.push_back(r);
		endfunction

		// Compare one result transaction with the oldest prediction
		function void check_result(logic [OUT_W-1:0] data);
			stack_result_t want;
			coord_t        got_x, got_y;
			logic          got_found;
			logic [1:0]    got_status;
			got_x      = data[COORD_BITS-1:0];
			got_y      = data[2*COORD_BITS-1:COORD_BITS];
			got_found  = data[2*COORD_BITS];
			got_status = data[2*COORD_BITS+2:2*COORD_BITS+1];
			if (owed_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("[%0t] unexpected result x=%0d y=%0d found=%0b status=%0d",
						$realtime, got_x, got_y, got_found, got_status);
				return;
			end
			want = owed_results.pop_front();
			results_checked++;
			if (got_x !== want.top_x || got_y !== want.top_y ||
					got_found !== want.found || got_status !== want.status) begin
				mismatches++;
				errors++;
				if (errors <= MAX_REPORTS)
					$display("[%0t] result #%0d: exp x=%0d y=%0d found=%0b status=%0d,",
						$realtime, results_checked, want.top_x, want.top_y, want.found,
						want.status, " got x=%0d y=%0d found=%0b status=%0d",
						got_x, got_y, got_found, got_status);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [IN_W-1:0]     s_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OUT_W-1:0]    m_axis_tdata;

	coord_stack_checker sb;
	int                 cycle_count = 0;
	bit                 tx_quiet = 1'b0;
	bit                 rx_quiet = 1'b0;
	pair_t              recent_pairs[$];

	coordinate_stack_with_search_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Clock and cycle count
	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("run exceeded %0d cycles", CYCLE_LIMIT);
		$display("** coordinate_stack_with_search_unit: FAILED **");
		$finish;
	end

	// Gap length: mostly none, some short, a few long
	function automatic int pick_gap(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Coordinate with extra weight on the corners of the range
	function automatic coord_t pick_coord();
		coord_t c;
		c = coord_t'($urandom);
		case ($urandom_range(0, 19))
			0: c = {1'b1, {(COORD_BITS-1){1'b0}}};
			1: c = {1'b0, {(COORD_BITS-1){1'b1}}};
			2: c = '1;
			3: c = '0;
			4: c = coord_t'(1);
			default: ;
		endcase
		return c;
	endfunction

	// Opcode weighted by phase: fill drives toward full, drain toward empty
	function automatic op_e_t pick_op(phase_t ph);
		int r;
		int t_push, t_peek, t_pop;
		r = $urandom_range(0, 99);
		case (ph)
			PH_FILL:  begin t_push = 70; t_peek = 75; t_pop = 85; end
			PH_DRAIN: begin t_push = 10; t_peek = 20; t_pop = 85; end
			default:  begin t_push = 25; t_peek = 50; t_pop = 75; end
		endcase
		if (r < t_push) return OP_PUSH;
		if (r < t_peek) return OP_PEEK;
		if (r < t_pop)  return OP_POP;
		return OP_SEARCH;
	endfunction

	// One command transaction on s_axis; returns after it is accepted
	task automatic send_command(op_e_t op, coord_t x, coord_t y);
		int gap;
		pair_t p;
		gap = pick_gap(tx_quiet);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_W-IN_BITS){1'b0}}, y, x, op};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		sb.accept_command(op, x, y);
		if (op == OP_PUSH) begin
			p.x = x;
			p.y = y;
			recent_pairs.push_back(p);
			if (recent_pairs.size() > POOL_SIZE) void'(recent_pairs.pop_front());
		end
	endtask

	// Random command: push values and search keys often reuse recent pairs
	task automatic send_random(phase_t ph);
		op_e_t  op;
		coord_t x, y;
		pair_t  p;
		int     r;
		op = pick_op(ph);
		x  = pick_coord();
		y  = pick_coord();
		r  = $urandom_range(0, 99);
		if (recent_pairs.size() > 0 && (op == OP_SEARCH ? r < 75 : r < 15)) begin
			p = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
			x = p.x;
			y = p.y;
			// near miss: one bit off in one coordinate
			if (op == OP_SEARCH && r < 25) begin
				if (r[0]) x[$urandom_range(0, COORD_BITS-1)] ^= 1'b1;
				else      y[$urandom_range(0, COORD_BITS-1)] ^= 1'b1;
			end
		end
		send_command(op, x, y);
	endtask

	// Result side: random stalls, with stall-free stretches
	initial begin
		int stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left == 0 && !rx_quiet && $urandom_range(0, 99) < 25)
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				                                         : $urandom_range(1, 3);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
			sb.check_result(m_axis_tdata);
	end

	// Stimulus and verdict
	initial begin
		coord_t cmin, cmax;
		phase_t ph;
		int     phase_len;
		int     random_sent;
		cmin = {1'b1, {(COORD_BITS-1){1'b0}}};
		cmax = {1'b0, {(COORD_BITS-1){1'b1}}};
		random_sent = 0;
		sb = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty stack, corner values, hit and miss, pop down to empty
		send_command(OP_SEARCH, '0, '0);
		send_command(OP_PEEK, cmax, cmax);
		send_command(OP_POP, cmin, cmin);
		send_command(OP_PUSH, cmin, cmax);
		send_command(OP_PUSH, cmax, cmin);
		send_command(OP_PUSH, '1, '1);
		send_command(OP_PUSH, '0, '0);
		send_command(OP_PEEK, '0, '0);
		send_command(OP_SEARCH, '1, '1);
		send_command(OP_SEARCH, '1, '0);
		send_command(OP_SEARCH, cmin, cmax);
		send_command(OP_SEARCH, cmax, cmax);
		send_command(OP_POP, '0, '0);
		send_command(OP_SEARCH, '0, '0);
		send_command(OP_POP, '0, '0);
		send_command(OP_PEEK, '0, '0);
		send_command(OP_POP, '0, '0);
		send_command(OP_POP, '0, '0);
		send_command(OP_POP, '0, '0);
		send_command(OP_PEEK, '0, '0);
		send_command(OP_SEARCH, cmin, cmax);

		// Random phases; fill phases run long enough to hit the full limit
		while (random_sent < RANDOM_ITEMS) begin
			ph = phase_t'($urandom_range(0, 2));
			phase_len = (ph == PH_FILL) ? $urandom_range(120, 200)
			                            : $urandom_range(30, 120);
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
				send_random(ph);
				random_sent++;
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;

		// Drain outstanding results, then watch for strays
		while (sb.owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Commands: %0d push (%0d refused as full), %0d peek/pop (%0d on empty),",
			sb.n_push, sb.n_full, sb.n_read, sb.n_empty,
			" %0d search (%0d hits)", sb.n_search, sb.n_hit);
		$display("Results checked: %0d, mismatches: %0d, other errors: %0d,",
			sb.results_checked, sb.mismatches, sb.errors - sb.mismatches,
			" deepest stack %0d of %0d", sb.peak_held, STACK_DEPTH);
		if (sb.errors == 0 && sb.owed_results.size() == 0) begin
			$display("** coordinate_stack_with_search_unit: PASSED **");
		end else begin
			$display("** coordinate_stack_with_search_unit: FAILED **");
		end
		$finish;
	end

endmodule
